/* src/vts_pkg.sv */
// Shared types and constants for the vruntime task scheduler.
// No dependencies; the cell, the scheduler top and the bench refer to this package by scoped names.
package vts_pkg;

    localparam int KEY_W  = 64;
    localparam int WKEY_W = 32;
    localparam int TID_W  = 16;   // widest task id any configuration may use
    localparam int IDX_W  = 8;    // holds a slot number for up to 256 slots

    typedef logic [2:0] t_op;
    localparam t_op OP_ADD   = 3'd0;
    localparam t_op OP_TICK  = 3'd1;
    localparam t_op OP_SLEEP = 3'd2;
    localparam t_op OP_WAIT  = 3'd3;
    localparam t_op OP_EXIT  = 3'd4;
    localparam t_op OP_WAKE  = 3'd5;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_RUN   = 2'd0;
    localparam t_mode MODE_SLEEP = 2'd1;
    localparam t_mode MODE_WAIT  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_IGN  = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    // Running summary handed from cell to cell along the chain.
    typedef struct packed {
        logic              hit;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              best_found;
        logic [KEY_W-1:0]  best_key;
        logic [TID_W-1:0]  best_task;
        logic [IDX_W-1:0]  best_idx;
    } t_chain;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic              age_en;
        logic [KEY_W-1:0]  elapsed;
        logic              wake_en;
        logic [WKEY_W-1:0] ev;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic              wr_clear;
        logic [TID_W-1:0]  wr_task;
        logic [KEY_W-1:0]  wr_key;
        t_mode             wr_mode;
        logic              sleep_we;
        logic [KEY_W-1:0]  sleep_val;
        logic              wait_we;
        logic [WKEY_W-1:0] wait_val;
    } t_cell_ctl;

endpackage

/* src/vts_if.sv */
// Request and response channel interfaces of the vruntime task scheduler.
// Depends on nothing; widths follow the fixed field widths.
interface vts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  task_id;
    logic [63:0] now;
    logic [63:0] sleep_count;
    logic [31:0] event_req;

    modport source (output valid, op, task_id, now, sleep_count, event_req, input ready);
    modport sink   (input valid, op, task_id, now, sleep_count, event_req, output ready);
endinterface

interface vts_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] current_task;
    logic       current_is_idle;
    logic [1:0] status;
    logic       tick_request;

    modport source (output valid, current_task, current_is_idle, status, tick_request,
                    input ready);
    modport sink   (input valid, current_task, current_is_idle, status, tick_request,
                    output ready);
endinterface

/* src/vts_cell.sv */
// One table slot of the scheduler: holds a task entry and folds it into the
// summary passed along the chain. Uses vts_pkg.
module vts_cell #(
    parameter int IDX      = 0,
    parameter int TID_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vts_pkg::t_cell_ctl i_ctl,
    input  logic [63:0]        i_key,
    input  vts_pkg::t_chain    i_chain,
    output vts_pkg::t_chain    o_chain,
    output logic               o_wake_hit
);

    logic                 r_valid;
    logic [TID_BITS-1:0]  r_task;
    logic [63:0]          r_key;
    vts_pkg::t_mode       r_mode;
    logic [63:0]          r_sleep;
    logic [31:0]          r_wait;
    vts_pkg::t_chain      r_chain;
    vts_pkg::t_chain      n_chain;
    logic                 w_sel;
    logic                 w_sleeper;

    assign w_sel      = i_ctl.wr_en && (i_ctl.wr_idx == vts_pkg::IDX_W'(IDX));
    assign w_sleeper  = r_valid && (r_mode == vts_pkg::MODE_SLEEP);
    assign o_wake_hit = i_ctl.wake_en && r_valid && (r_mode == vts_pkg::MODE_WAIT)
                        && (r_wait == i_ctl.ev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            r_valid <= !i_ctl.wr_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && !i_ctl.wr_clear) begin
            r_task <= i_ctl.wr_task[TID_BITS-1:0];
            r_key  <= i_ctl.wr_key;
            r_mode <= i_ctl.wr_mode;
        end else if (i_ctl.age_en && w_sleeper) begin
            if (i_ctl.elapsed >= r_sleep) begin
                r_mode <= vts_pkg::MODE_RUN;
            end
        end else if (o_wake_hit) begin
            r_mode <= vts_pkg::MODE_RUN;
        end
        if (w_sel && i_ctl.sleep_we) begin
            r_sleep <= i_ctl.sleep_val;
        end else if (i_ctl.age_en && w_sleeper && (i_ctl.elapsed < r_sleep)) begin
            r_sleep <= r_sleep - i_ctl.elapsed;
        end
        if (w_sel && i_ctl.wait_we) begin
            r_wait <= i_ctl.wait_val;
        end
    end

    always_comb begin
        n_chain = i_chain;
        if (r_valid && (r_key == i_key)) begin
            n_chain.hit = 1'b1;
        end
        if (!r_valid && !i_chain.free_found) begin
            n_chain.free_found = 1'b1;
            n_chain.free_idx   = vts_pkg::IDX_W'(IDX);
        end
        if (r_valid && (r_mode == vts_pkg::MODE_RUN)
            && (!i_chain.best_found || (r_key < i_chain.best_key))) begin
            n_chain.best_found = 1'b1;
            n_chain.best_key   = r_key;
            n_chain.best_task  = vts_pkg::TID_W'(r_task);
            n_chain.best_idx   = vts_pkg::IDX_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_chain <= n_chain;
    end

    assign o_chain = r_chain;

endmodule

/* src/vruntime_task_scheduler.sv */
// Vruntime task scheduler: a row of MAX_TASKS slot cells, each holding one
// waiting task, walked by a sequencer. One request is handled at a time. An
// ignored request goes straight to the response; a wake passes through the
// preparation and commit steps. Every other request sweeps the cell chain, in
// which the slot summary moves one cell per cycle; add, and tick, sleep and
// wait while a task runs, repeat the sweep once for every key collision they
// bump past. A request passes through preparation, aging for a tick, key
// setup, sweep and commit, then waits for the response to be taken. The
// response holds until taken.
module vruntime_task_scheduler #(
    parameter int MAX_TASKS    = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vts_req_if.sink     i_req,
    vts_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_AGE    = 7'b0000100,
        S_KEY    = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state                  r_state;
    logic                    r_enable;
    vts_pkg::t_op            r_op;
    logic [TASK_ID_BITS-1:0] r_tid;
    logic [63:0]             r_now;
    logic [63:0]             r_sc;
    logic [31:0]             r_ev;
    logic [TASK_ID_BITS-1:0] r_run_task;
    logic                    r_run_idle;
    logic [63:0]             r_run_rt;
    logic [63:0]             r_idle_rt;
    logic [63:0]             r_start;
    logic [63:0]             r_last;
    logic [63:0]             r_diff;
    logic [63:0]             r_elapsed;
    logic [63:0]             r_k;
    logic [CNT_W-1:0]        r_cnt;
    vts_pkg::t_status        r_status;
    logic                    r_treq;

    vts_pkg::t_chain         w_chain [MAX_TASKS+1];
    logic [MAX_TASKS-1:0]    w_hit;
    vts_pkg::t_cell_ctl      w_ctl;
    vts_pkg::t_chain         w_tail;
    logic                    w_ignore;
    logic                    w_need_key;
    logic                    w_cur_op;
    logic [15:0]             w_tid16;
    logic [15:0]             w_run16;

    assign w_chain[0] = '0;
    assign w_tail     = w_chain[MAX_TASKS];

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        vts_cell #(
            .IDX      (g),
            .TID_BITS (TASK_ID_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (r_k),
            .i_chain    (w_chain[g]),
            .o_chain    (w_chain[g+1]),
            .o_wake_hit (w_hit[g])
        );
    end

    // Configuration port: a single register, decoded regardless of address.
    assign pready = 1'b1;
    assign prdata = {31'd0, r_enable};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite) begin
            r_enable <= pwdata[0];
        end
    end

    assign w_tid16  = 16'(i_req.task_id);
    assign w_run16  = 16'(r_run_task);
    assign w_cur_op = (i_req.op == vts_pkg::OP_SLEEP) || (i_req.op == vts_pkg::OP_WAIT)
                      || (i_req.op == vts_pkg::OP_EXIT);
    assign w_ignore = !r_enable || (i_req.op > vts_pkg::OP_WAKE)
                      || (w_cur_op && r_run_idle)
                      || ((i_req.op == vts_pkg::OP_WAKE) && !r_run_idle);
    assign w_need_key = (r_op == vts_pkg::OP_ADD)
                        || (!r_run_idle && ((r_op == vts_pkg::OP_TICK)
                        || (r_op == vts_pkg::OP_SLEEP) || (r_op == vts_pkg::OP_WAIT)));

    always_comb begin
        w_ctl           = '0;
        w_ctl.elapsed   = r_elapsed;
        w_ctl.ev        = r_ev;
        w_ctl.wr_key    = r_k;
        w_ctl.wr_task   = w_run16;
        w_ctl.wr_mode   = vts_pkg::MODE_RUN;
        w_ctl.sleep_val = r_sc;
        w_ctl.wait_val  = r_ev;
        if (r_state == S_AGE) begin
            w_ctl.age_en = 1'b1;
        end
        if (r_state == S_COMMIT) begin
            case (r_op)
                vts_pkg::OP_WAKE: begin
                    w_ctl.wake_en = 1'b1;
                end
                vts_pkg::OP_ADD: begin
                    w_ctl.wr_en   = w_tail.free_found;
                    w_ctl.wr_idx  = w_tail.free_idx;
                    w_ctl.wr_task = 16'(r_tid);
                end
                vts_pkg::OP_TICK: begin
                    w_ctl.wr_idx = w_tail.best_idx;
                    if (r_run_idle) begin
                        w_ctl.wr_en    = w_tail.best_found;
                        w_ctl.wr_clear = 1'b1;
                    end else begin
                        w_ctl.wr_en = w_tail.best_found && (w_tail.best_key < r_k);
                    end
                end
                vts_pkg::OP_SLEEP, vts_pkg::OP_WAIT: begin
                    w_ctl.wr_en    = w_tail.best_found || w_tail.free_found;
                    w_ctl.wr_idx   = w_tail.best_found ? w_tail.best_idx : w_tail.free_idx;
                    w_ctl.wr_mode  = (r_op == vts_pkg::OP_SLEEP) ? vts_pkg::MODE_SLEEP
                                                                : vts_pkg::MODE_WAIT;
                    w_ctl.sleep_we = (r_op == vts_pkg::OP_SLEEP);
                    w_ctl.wait_we  = (r_op == vts_pkg::OP_WAIT);
                end
                vts_pkg::OP_EXIT: begin
                    w_ctl.wr_en    = w_tail.best_found;
                    w_ctl.wr_idx   = w_tail.best_idx;
                    w_ctl.wr_clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_run_task <= '0;
            r_run_idle <= 1'b1;
            r_run_rt   <= '0;
            r_idle_rt  <= '0;
            r_start    <= '0;
            r_last     <= '0;
            r_cnt      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= w_ignore ? S_OUT : S_PREP;
                    end
                end
                S_PREP: begin
                    case (r_op)
                        vts_pkg::OP_WAKE: r_state <= S_COMMIT;
                        vts_pkg::OP_TICK: r_state <= S_AGE;
                        default:          r_state <= S_KEY;
                    endcase
                end
                S_AGE: begin
                    r_state <= S_KEY;
                end
                S_KEY: begin
                    r_cnt   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_cnt == CNT_W'(MAX_TASKS)) begin
                        r_cnt <= '0;
                        if (!(w_need_key && w_tail.hit)) begin
                            r_state <= S_COMMIT;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_COMMIT: begin
                    r_state <= S_OUT;
                    case (r_op)
                        vts_pkg::OP_TICK: begin
                            r_start <= r_now;
                            r_last  <= r_now;
                            if (r_run_idle) begin
                                r_idle_rt <= r_idle_rt + r_diff;
                                if (w_tail.best_found) begin
                                    r_run_task <= w_tail.best_task[TASK_ID_BITS-1:0];
                                    r_run_rt   <= w_tail.best_key;
                                    r_run_idle <= 1'b0;
                                end
                            end else if (w_tail.best_found && (w_tail.best_key < r_k)) begin
                                r_run_task <= w_tail.best_task[TASK_ID_BITS-1:0];
                                r_run_rt   <= w_tail.best_key;
                            end else begin
                                r_run_rt <= r_k;
                            end
                        end
                        vts_pkg::OP_SLEEP, vts_pkg::OP_WAIT: begin
                            if (w_tail.best_found) begin
                                r_run_task <= w_tail.best_task[TASK_ID_BITS-1:0];
                                r_run_rt   <= w_tail.best_key;
                                r_start    <= r_now;
                            end else if (w_tail.free_found) begin
                                r_run_idle <= 1'b1;
                                r_start    <= r_now;
                            end
                        end
                        vts_pkg::OP_EXIT: begin
                            r_start <= r_now;
                            if (w_tail.best_found) begin
                                r_run_task <= w_tail.best_task[TASK_ID_BITS-1:0];
                                r_run_rt   <= w_tail.best_key;
                            end else begin
                                r_run_idle <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op     <= i_req.op;
                r_tid    <= w_tid16[TASK_ID_BITS-1:0];
                r_now    <= i_req.now;
                r_sc     <= i_req.sleep_count;
                r_ev     <= i_req.event_req;
                r_status <= w_ignore ? vts_pkg::ST_IGN : vts_pkg::ST_DONE;
                r_treq   <= 1'b0;
            end
            S_PREP: begin
                r_diff    <= r_now - r_start;
                r_elapsed <= r_now - r_last;
            end
            S_KEY: begin
                r_k <= (r_op == vts_pkg::OP_ADD) ? 64'd0 : r_run_rt + r_diff;
            end
            S_SCAN: begin
                // A collision bumps the key and starts a fresh sweep.
                if ((r_cnt == CNT_W'(MAX_TASKS)) && w_need_key && w_tail.hit) begin
                    r_k <= r_k + 64'd1;
                end
            end
            S_COMMIT: begin
                r_treq <= (r_op == vts_pkg::OP_WAKE) && (|w_hit);
                if ((r_op == vts_pkg::OP_ADD) && !w_tail.free_found) begin
                    r_status <= vts_pkg::ST_FULL;
                end
                if (((r_op == vts_pkg::OP_SLEEP) || (r_op == vts_pkg::OP_WAIT))
                    && !w_tail.best_found && !w_tail.free_found) begin
                    r_status <= vts_pkg::ST_FULL;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = (r_state == S_OUT);
    assign o_rsp.current_task    = r_run_idle ? 8'd0 : w_run16[7:0];
    assign o_rsp.current_is_idle = r_run_idle;
    assign o_rsp.status          = r_status;
    assign o_rsp.tick_request    = r_treq;

endmodule

/* src/vts_checker.sv */
// Port-level checks for the vruntime task scheduler, bound to the top level.
// Depends on the top level's ports only.
module vts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [7:0] i_rsp_task,
    input logic       i_rsp_idle,
    input logic [1:0] i_rsp_status,
    input logic       i_rsp_treq
);

    // One request in flight: after acceptance no new request is taken at once.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another was in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("ready for a request while a response is pending");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)))
        else $error("response dropped or changed before it was taken");

    a_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_idle) |-> (i_rsp_task == 8'd0))
        else $error("idle task reported with a nonzero task id");

    a_treq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_treq) |-> (i_rsp_idle && (i_rsp_status == 2'd0)))
        else $error("tick request without a completed wake while idle");

endmodule

bind vruntime_task_scheduler vts_checker u_vts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_task   (o_rsp.current_task),
    .i_rsp_idle   (o_rsp.current_is_idle),
    .i_rsp_status (o_rsp.status),
    .i_rsp_treq   (o_rsp.tick_request)
);

/* bench/tb.sv */
// Self-checking bench for the vruntime task scheduler: drives scheduling requests
// and APB writes, and predicts every response with its own copy of the task table.
// Depends on vts_pkg, the vts_req_if / vts_rsp_if interfaces and the scheduler top.
`timescale 1ns / 100ps

module tb;

    localparam int NSLOT     = 16;
    localparam int MAX_CYC   = 3000000;
    localparam logic [1:0] REG_ENABLE = 2'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vts_req_if req_ch ();
    vts_rsp_if rsp_ch ();

    vruntime_task_scheduler #(.MAX_TASKS(NSLOT), .TASK_ID_BITS(8)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    typedef struct {
        logic [7:0]       cur_task;
        logic             cur_idle;
        vts_pkg::t_status status;
        logic             tick_req;
    } t_sched_rsp;

    class sched_board;
        logic           valid_q [NSLOT];
        logic [7:0]     task_q [NSLOT];
        logic [63:0]    key_q [NSLOT];
        vts_pkg::t_mode mode_q [NSLOT];
        logic [63:0]    sleep_q [NSLOT];
        logic [31:0]    wkey_q [NSLOT];
        logic [7:0]     run_task;
        logic           run_idle;
        logic [63:0]    run_time, idle_time, start_t, last_t;
        logic           enabled;
        t_sched_rsp     pending [$];
        int             errors;

        function new();
            foreach (valid_q[i]) valid_q[i] = 1'b0;
            run_task = '0; run_idle = 1'b1; run_time = '0;
            idle_time = '0; start_t = '0; last_t = '0;
            enabled = 1'b0; errors = 0;
        endfunction

        function logic [63:0] free_key(logic [63:0] k);
            logic hit;
            for (int n = 0; n <= NSLOT; n++) begin
                hit = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                    if (valid_q[i] && key_q[i] == k) hit = 1'b1;
                if (!hit) break;
                k = k + 64'd1;
            end
            return k;
        endfunction

        function int lowest_ready();
            int best;
            best = -1;
            for (int i = 0; i < NSLOT; i++)
                if (valid_q[i] && mode_q[i] == vts_pkg::MODE_RUN &&
                    (best < 0 || key_q[i] < key_q[best])) best = i;
            return best;
        endfunction

        function int empty_slot();
            for (int i = 0; i < NSLOT; i++)
                if (!valid_q[i]) return i;
            return -1;
        endfunction

        function void note_request(vts_pkg::t_op op, logic [7:0] tid, logic [63:0] now,
                                   logic [63:0] sc, logic [31:0] ev);
            t_sched_rsp  r;
            int          s, lo;
            logic [63:0] vrt, elapsed, k;
            logic [7:0]  t;
            r.status = vts_pkg::ST_IGN;
            r.tick_req = 1'b0;
            if (enabled) begin
                case (op)
                    vts_pkg::OP_ADD: begin
                        s = empty_slot();
                        if (s < 0) r.status = vts_pkg::ST_FULL;
                        else begin
                            vrt = free_key(64'd0);
                            valid_q[s] = 1'b1; task_q[s] = tid;
                            key_q[s] = vrt; mode_q[s] = vts_pkg::MODE_RUN;
                            r.status = vts_pkg::ST_DONE;
                        end
                    end
                    vts_pkg::OP_TICK: begin
                        elapsed = now - last_t;
                        for (int i = 0; i < NSLOT; i++)
                            if (valid_q[i] && mode_q[i] == vts_pkg::MODE_SLEEP) begin
                                if (elapsed >= sleep_q[i]) mode_q[i] = vts_pkg::MODE_RUN;
                                else sleep_q[i] = sleep_q[i] - elapsed;
                            end
                        if (run_idle) begin
                            idle_time = idle_time + (now - start_t);
                            lo = lowest_ready();
                            if (lo >= 0) begin
                                run_task = task_q[lo]; run_time = key_q[lo];
                                run_idle = 1'b0; valid_q[lo] = 1'b0;
                            end
                        end else begin
                            vrt = free_key(run_time + (now - start_t));
                            lo = lowest_ready();
                            if (lo >= 0 && key_q[lo] < vrt) begin
                                t = task_q[lo]; k = key_q[lo];
                                task_q[lo] = run_task; key_q[lo] = vrt;
                                mode_q[lo] = vts_pkg::MODE_RUN;
                                run_task = t; run_time = k;
                            end else run_time = vrt;
                        end
                        start_t = now; last_t = now;
                        r.status = vts_pkg::ST_DONE;
                    end
                    vts_pkg::OP_SLEEP, vts_pkg::OP_WAIT: if (!run_idle) begin
                        vrt = free_key(run_time + (now - start_t));
                        lo = lowest_ready();
                        s = (lo >= 0) ? lo : empty_slot();
                        if (s < 0) r.status = vts_pkg::ST_FULL;
                        else begin
                            t = (lo >= 0) ? task_q[lo] : 8'd0;
                            k = (lo >= 0) ? key_q[lo] : 64'd0;
                            valid_q[s] = 1'b1; task_q[s] = run_task; key_q[s] = vrt;
                            mode_q[s] = (op == vts_pkg::OP_SLEEP) ? vts_pkg::MODE_SLEEP
                                                                  : vts_pkg::MODE_WAIT;
                            if (op == vts_pkg::OP_SLEEP) sleep_q[s] = sc;
                            else wkey_q[s] = ev;
                            if (lo >= 0) begin
                                run_task = t; run_time = k;
                            end else run_idle = 1'b1;
                            start_t = now;
                            r.status = vts_pkg::ST_DONE;
                        end
                    end
                    vts_pkg::OP_EXIT: if (!run_idle) begin
                        lo = lowest_ready();
                        if (lo >= 0) begin
                            run_task = task_q[lo]; run_time = key_q[lo];
                            valid_q[lo] = 1'b0;
                        end else run_idle = 1'b1;
                        start_t = now;
                        r.status = vts_pkg::ST_DONE;
                    end
                    vts_pkg::OP_WAKE: if (run_idle) begin
                        for (int i = 0; i < NSLOT; i++)
                            if (valid_q[i] && mode_q[i] == vts_pkg::MODE_WAIT
                                && wkey_q[i] == ev) begin
                                mode_q[i] = vts_pkg::MODE_RUN;
                                r.tick_req = 1'b1;
                            end
                        r.status = vts_pkg::ST_DONE;
                    end
                    default: ;
                endcase
            end
            r.cur_task = run_idle ? 8'd0 : run_task;
            r.cur_idle = run_idle;
            pending.push_back(r);
        endfunction

        function void check_response(logic [7:0] cur_task, logic cur_idle,
                                     logic [1:0] status, logic tick_req);
            t_sched_rsp e;
            if (pending.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (cur_task !== e.cur_task) begin
                $error("current_task: expected %0d, got %0d", e.cur_task, cur_task);
                errors++;
            end
            if (cur_idle !== e.cur_idle) begin
                $error("current_is_idle: expected %0d, got %0d", e.cur_idle, cur_idle);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (tick_req !== e.tick_req) begin
                $error("tick_request: expected %0d, got %0d", e.tick_req, tick_req);
                errors++;
            end
        endfunction
    endclass

    sched_board board = new();
    int          cycle_cnt;
    int          burst_left;
    int          stall_mode;
    logic [63:0] clock_now;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYC) begin
            $display("vruntime_task_scheduler: mismatch");
            $finish;
        end
    end

    // The receiver checks every response it takes and draws its stall habit anew at random.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.current_task, rsp_ch.current_is_idle,
                                 rsp_ch.status, rsp_ch.tick_request);
        if (cycle_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= cycle_cnt[0];
            2: rsp_ch.ready <= $urandom_range(0, 1);
            default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_ENABLE) board.enabled = data[0];
    endtask

    // Holds the request until the scheduler takes it, then keeps the burst going or pauses.
    task automatic send_request(vts_pkg::t_op op, logic [7:0] tid, logic [63:0] now,
                                logic [63:0] sc, logic [31:0] ev);
        req_ch.valid <= 1'b1;
        req_ch.op <= op; req_ch.task_id <= tid; req_ch.now <= now;
        req_ch.sleep_count <= sc; req_ch.event_req <= ev;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(op, tid, now, sc, ev);
        burst_left--;
        if (burst_left <= 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        if (req_ch.valid) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic random_requests(int count);
        vts_pkg::t_op op;
        int           pick;
        logic [63:0]  sc;
        logic [31:0]  ev;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) op = vts_pkg::OP_ADD;
            else if (pick < 55) op = vts_pkg::OP_TICK;
            else if (pick < 67) op = vts_pkg::OP_SLEEP;
            else if (pick < 79) op = vts_pkg::OP_WAIT;
            else if (pick < 87) op = vts_pkg::OP_EXIT;
            else if (pick < 97) op = vts_pkg::OP_WAKE;
            else op = vts_pkg::t_op'($urandom_range(6, 7));
            if ($urandom_range(0, 49) == 0) clock_now = {$urandom, $urandom};
            else clock_now = clock_now + 64'($urandom_range(0, 300));
            sc = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 800));
            ev = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 3);
            send_request(op, 8'($urandom_range(0, 255)), clock_now, sc, ev);
        end
    endtask

    initial begin
        cycle_cnt = 0;
        stall_mode = 0;
        burst_left = 4;
        clock_now = '0;
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        req_ch.valid <= 1'b0; req_ch.op <= vts_pkg::OP_ADD; req_ch.task_id <= '0;
        req_ch.now <= '0; req_ch.sleep_count <= '0; req_ch.event_req <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Disabled scheduler: every request is answered as ignored.
        apb_write(REG_ENABLE, 32'd0);
        random_requests(10);
        drain();
        apb_write(REG_ENABLE, 32'hFFFF_FFFF);

        // Directed: ops while idle, then a short life cycle of two tasks.
        send_request(vts_pkg::OP_EXIT, 8'd0, 64'd10, 64'd0, 32'd0);
        send_request(vts_pkg::OP_SLEEP, 8'd0, 64'd11, 64'd5, 32'd0);
        send_request(vts_pkg::OP_WAIT, 8'd0, 64'd12, 64'd0, 32'd7);
        send_request(vts_pkg::OP_WAKE, 8'd0, 64'd13, 64'd0, 32'd7);
        send_request(vts_pkg::OP_TICK, 8'd0, 64'd20, 64'd0, 32'd0);
        send_request(vts_pkg::OP_ADD, 8'hFF, 64'd21, 64'd0, 32'd0);
        send_request(vts_pkg::OP_ADD, 8'h00, 64'd22, 64'd0, 32'd0);
        send_request(vts_pkg::OP_TICK, 8'd0, 64'd30, 64'd0, 32'd0);
        send_request(vts_pkg::OP_WAKE, 8'd0, 64'd31, 64'd0, 32'd9);
        send_request(vts_pkg::OP_WAIT, 8'd0, 64'd40, 64'd0, 32'hFFFF_FFFF);
        send_request(vts_pkg::OP_SLEEP, 8'd0, 64'd50, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(vts_pkg::OP_WAKE, 8'd0, 64'd51, 64'd0, 32'hFFFF_FFFF);
        send_request(vts_pkg::OP_TICK, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd0);
        send_request(vts_pkg::t_op'(3'd6), 8'd0, 64'd60, 64'd0, 32'd0);
        send_request(vts_pkg::t_op'(3'd7), 8'hAA, 64'd61, 64'd0, 32'd0);
        send_request(vts_pkg::OP_TICK, 8'd0, 64'd70, 64'd0, 32'd0);
        send_request(vts_pkg::OP_EXIT, 8'd0, 64'd80, 64'd0, 32'd0);
        send_request(vts_pkg::OP_EXIT, 8'd0, 64'd90, 64'd0, 32'd0);
        // Fill the table and overflow it once.
        for (int i = 0; i < NSLOT + 1; i++)
            send_request(vts_pkg::OP_ADD, 8'(i * 17), 64'd100, 64'd0, 32'd0);
        clock_now = 64'd200;

        random_requests(700);
        drain();
        apb_write(REG_ENABLE, 32'd0);
        random_requests(20);
        drain();
        apb_write(REG_ENABLE, 32'd1);
        random_requests(720);
        drain();
        repeat (400) @(posedge i_clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("vruntime_task_scheduler: match");
        else
            $display("vruntime_task_scheduler: mismatch");
        $finish;
    end
endmodule

/* sim.f */
src/vts_pkg.sv
src/vts_if.sv
src/vts_cell.sv
src/vruntime_task_scheduler.sv
src/vts_checker.sv
bench/tb.sv
